@@ rtl/pf_pkg.sv @@
`timescale 1ns / 1ps

package pf_pkg;

  localparam int GRID_SIDE  = 5;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int LETTERS    = 26;
  localparam int LETTER_W   = 5;
  localparam int CELL_W     = 5;
  localparam int SIDE_W     = 3;
  localparam int CHAR_W     = 8;
  localparam int ASCII_W    = 7;

  localparam logic [1:0] REQ_KEY_LETTER = 2'd0;
  localparam logic [1:0] REQ_KEY_END    = 2'd1;
  localparam logic [1:0] REQ_TEXT_CHAR  = 2'd2;
  localparam logic [1:0] REQ_TEXT_END   = 2'd3;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CELL_W-1:0]   cell_t;
  typedef logic [SIDE_W-1:0]   side_t;
  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [ASCII_W-1:0]  ascii_t;

  localparam letter_t IDX_I = 5'd8;
  localparam letter_t IDX_J = 5'd9;
  localparam letter_t IDX_X = 5'd23;

  localparam ascii_t ASCII_A = 7'd65;
  localparam char_t CHAR_UPPER_A = 8'd65;
  localparam char_t CHAR_UPPER_Z = 8'd90;
  localparam char_t CHAR_LOWER_A = 8'd97;
  localparam char_t CHAR_LOWER_Z = 8'd122;

  typedef struct packed {
    logic    ok;
    letter_t idx;
  } letter_code_t;

  // Upper-case, merge J into I; ok is low for anything that is not a letter.
  function automatic letter_code_t letter_of(input char_t c);
    letter_code_t r;
    char_t        v;
    r.ok  = 1'b0;
    r.idx = '0;
    v     = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r.ok = 1'b1;
      v    = c - CHAR_UPPER_A;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r.ok = 1'b1;
      v    = c - CHAR_LOWER_A;
    end
    r.idx = letter_t'(v);
    if (r.idx == IDX_J) r.idx = IDX_I;
    return r;
  endfunction

  function automatic side_t row_of(input cell_t s);
    side_t r;
    if (s >= cell_t'(4 * GRID_SIDE))      r = side_t'(4);
    else if (s >= cell_t'(3 * GRID_SIDE)) r = side_t'(3);
    else if (s >= cell_t'(2 * GRID_SIDE)) r = side_t'(2);
    else if (s >= cell_t'(GRID_SIDE))     r = side_t'(1);
    else                                  r = side_t'(0);
    return r;
  endfunction

  function automatic side_t col_of(input cell_t s);
    cell_t base;
    base = cell_t'(cell_t'(row_of(s)) * cell_t'(GRID_SIDE));
    return side_t'(s - base);
  endfunction

  function automatic side_t wrap_inc(input side_t x);
    return (x == side_t'(GRID_SIDE - 1)) ? side_t'(0) : side_t'(x + side_t'(1));
  endfunction

  function automatic cell_t cell_at(input side_t r, input side_t c);
    return cell_t'(cell_t'(r) * cell_t'(GRID_SIDE) + cell_t'(c));
  endfunction

endpackage

@@ rtl/playfair_digraph_encryptor.sv @@
`timescale 1ns / 1ps

// Playfair encryptor over a 5x5 letter table.
// Input channel (in_valid/in_ready, req_type, char_code): keyword letters, a keyword
// end, then text characters and text ends. Output channel (out_valid/out_ready):
// one ciphertext digraph per transfer, last_pair set when it came from text-end padding.
// A keyword letter not yet in the table is written into the table and letter-slot
// memories at the transfer. Keyword end walks the 26 letters through the write ports,
// and the block holds in_ready low until the sweep is done. A text character that
// only opens a pair is held without leaving idle. A character or text end that closes
// a pair goes through two memory reads (letter slots, then table cells) in the slot,
// grid and emit states, and in_ready stays low until the block is back in idle.
// The output register lets the next item in while a result waits; a second result
// waits in the last stage, with in_ready low, until the receiver takes the first.
// Reset clears the table-ready flag, the fill count, the taken bits and the held
// letter; the table must then be built again before text is encrypted.
module playfair_digraph_encryptor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            req_type,
  input  logic [7:0]            char_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [6:0]            cipher_first,
  output logic [6:0]            cipher_second,
  output logic                  last_pair
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_SLOT = 3'd2;
  localparam logic [2:0] ST_GRID = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                      state;
  logic [pf_pkg::LETTERS-1:0]      letter_taken;
  pf_pkg::cell_t                   fill_count;
  logic                            grid_ready;
  pf_pkg::letter_t                 held_letter;
  logic                            held_valid;
  pf_pkg::letter_t                 fill_k;
  pf_pkg::letter_t                 pair_a;
  pf_pkg::letter_t                 pair_b;
  logic                            pair_last;

  logic                            in_fire;
  pf_pkg::letter_code_t            in_code;
  logic                            place_en;
  pf_pkg::letter_t                 place_letter;
  pf_pkg::cell_t                   slot_a;
  pf_pkg::cell_t                   slot_b;
  pf_pkg::letter_t                 grid_a;
  pf_pkg::letter_t                 grid_b;
  pf_pkg::cell_t                   gaddr_a;
  pf_pkg::cell_t                   gaddr_b;
  pf_pkg::side_t                   ar, ac, br, bc;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_code  = pf_pkg::letter_of(char_code);

  // One write port per memory serves both keyword letters and the fill sweep.
  always_comb begin
    place_en     = 1'b0;
    place_letter = in_code.idx;
    if (state == ST_FILL) begin
      place_letter = fill_k;
      place_en     = (fill_k != pf_pkg::IDX_J) && !letter_taken[fill_k] &&
                     (fill_count < pf_pkg::cell_t'(pf_pkg::GRID_CELLS));
    end else if (in_fire && req_type == pf_pkg::REQ_KEY_LETTER && !grid_ready &&
                 in_code.ok) begin
      place_en = !letter_taken[in_code.idx] &&
                 (fill_count < pf_pkg::cell_t'(pf_pkg::GRID_CELLS));
    end
  end

  pf_ram #(.WIDTH(pf_pkg::CELL_W), .DEPTH(pf_pkg::LETTERS)) u_slot_ram (
    .clk     (clk),
    .we      (place_en),
    .waddr   (place_letter),
    .wdata   (fill_count),
    .raddr_a (pair_a),
    .raddr_b (pair_b),
    .rdata_a (slot_a),
    .rdata_b (slot_b)
  );

  // Same row: step right; same column: step down; else swap rectangle corners.
  always_comb begin
    ar = pf_pkg::row_of(slot_a);
    ac = pf_pkg::col_of(slot_a);
    br = pf_pkg::row_of(slot_b);
    bc = pf_pkg::col_of(slot_b);
    if (ar == br) begin
      gaddr_a = pf_pkg::cell_at(ar, pf_pkg::wrap_inc(ac));
      gaddr_b = pf_pkg::cell_at(br, pf_pkg::wrap_inc(bc));
    end else if (ac == bc) begin
      gaddr_a = pf_pkg::cell_at(pf_pkg::wrap_inc(ar), ac);
      gaddr_b = pf_pkg::cell_at(pf_pkg::wrap_inc(br), bc);
    end else begin
      gaddr_a = pf_pkg::cell_at(ar, bc);
      gaddr_b = pf_pkg::cell_at(br, ac);
    end
  end

  pf_ram #(.WIDTH(pf_pkg::LETTER_W), .DEPTH(pf_pkg::GRID_CELLS)) u_grid_ram (
    .clk     (clk),
    .we      (place_en),
    .waddr   (fill_count),
    .wdata   (place_letter),
    .raddr_a (gaddr_a),
    .raddr_b (gaddr_b),
    .rdata_a (grid_a),
    .rdata_b (grid_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      letter_taken <= '0;
      fill_count   <= '0;
      grid_ready   <= 1'b0;
      held_letter  <= '0;
      held_valid   <= 1'b0;
      fill_k       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_EMIT) out_valid <= 1'b0;
      if (place_en) begin
        letter_taken[place_letter] <= 1'b1;
        fill_count                 <= fill_count + pf_pkg::cell_t'(1);
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (req_type)
              pf_pkg::REQ_KEY_END: begin
                if (!grid_ready) begin
                  fill_k <= '0;
                  state  <= ST_FILL;
                end
              end
              pf_pkg::REQ_TEXT_CHAR: begin
                if (grid_ready && in_code.ok) begin
                  if (!held_valid) begin
                    held_letter <= in_code.idx;
                    held_valid  <= 1'b1;
                  end else begin
                    pair_a    <= held_letter;
                    pair_last <= 1'b0;
                    // Doubled letter: pad with X and keep the letter held.
                    if (in_code.idx == held_letter) begin
                      pair_b <= pf_pkg::IDX_X;
                    end else begin
                      pair_b     <= in_code.idx;
                      held_valid <= 1'b0;
                    end
                    state <= ST_SLOT;
                  end
                end
              end
              pf_pkg::REQ_TEXT_END: begin
                if (grid_ready && held_valid) begin
                  pair_a     <= held_letter;
                  pair_b     <= pf_pkg::IDX_X;
                  pair_last  <= 1'b1;
                  held_valid <= 1'b0;
                  state      <= ST_SLOT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FILL: begin
          fill_k <= fill_k + pf_pkg::letter_t'(1);
          if (fill_k == pf_pkg::letter_t'(pf_pkg::LETTERS - 1)) begin
            grid_ready <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        ST_SLOT: state <= ST_GRID;
        ST_GRID: state <= ST_EMIT;
        ST_EMIT: begin
          // Hold until the output register is free; read addresses stay put.
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            cipher_first  <= pf_pkg::ASCII_A + pf_pkg::ascii_t'(grid_a);
            cipher_second <= pf_pkg::ASCII_A + pf_pkg::ascii_t'(grid_b);
            last_pair     <= pair_last;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && fill_k == pf_pkg::letter_t'(pf_pkg::LETTERS - 1)) |=>
      (grid_ready && fill_count == pf_pkg::cell_t'(pf_pkg::GRID_CELLS)))
    else $error("table not complete after fill sweep");

  a_held_needs_grid: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> grid_ready)
    else $error("letter held before table is ready");

  a_no_j_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cipher_first != pf_pkg::ASCII_A + pf_pkg::ascii_t'(pf_pkg::IDX_J) &&
                   cipher_second != pf_pkg::ASCII_A + pf_pkg::ascii_t'(pf_pkg::IDX_J)))
    else $error("ciphertext holds J");

  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SLOT) |=> (state == ST_GRID) ##1 (state == ST_EMIT))
    else $error("read pipeline skipped a stage");

endmodule

@@ rtl/pf_ram.sv @@
`timescale 1ns / 1ps

module pf_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
